// ----- src/lebwc_pkg.sv -----
// ----------------------------------------------------------------------------
// lebwc_pkg: shared types and constants for the width-checked LEB128 decoder
// Word layouts for both channels, the status codes and the decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

package lebwc_pkg;

  // Widest value the decoder is built for by default.
  localparam int MAX_WIDTH_DEF = 64;

  localparam logic [7:0] CONT_BIT = 8'h80;
  localparam logic [7:0] SIGN_BIT = 8'h40;
  localparam logic [7:0] PAY_MASK = 8'h7f;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [6:0] LAST_SHIFT = 7'd63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_END      = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic [6:0] target_width;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic [3:0]  byte_count;
  } out_word_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  idx;
    logic [6:0]  width;
    logic        sgn;
    logic        busy;
  } dec_state_t;

endpackage : lebwc_pkg

`default_nettype wire

// ----- src/lebwc_step.sv -----
// ----------------------------------------------------------------------------
// lebwc_step: one decode step
// Folds one byte into the decoder state and flags a finished value or error.
// ----------------------------------------------------------------------------
`default_nettype none

module lebwc_step #(
  parameter int MAX_WIDTH = lebwc_pkg::MAX_WIDTH_DEF
) (
  input  var lebwc_pkg::dec_state_t st_cur,
  input  var lebwc_pkg::in_word_t   word_in,
  output lebwc_pkg::dec_state_t     st_nxt,
  output logic                      res_valid,
  output lebwc_pkg::out_word_t      res_word
);

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  // Number of bytes allowed for a width, ceil(w/7).
  function automatic logic [3:0] bytes_for(input logic [6:0] w);
    logic [3:0] n;
    unique case (w) inside
      [7'd0:7'd7]:   n = 4'd1;
      [7'd8:7'd14]:  n = 4'd2;
      [7'd15:7'd21]: n = 4'd3;
      [7'd22:7'd28]: n = 4'd4;
      [7'd29:7'd35]: n = 4'd5;
      [7'd36:7'd42]: n = 4'd6;
      [7'd43:7'd49]: n = 4'd7;
      [7'd50:7'd56]: n = 4'd8;
      [7'd57:7'd63]: n = 4'd9;
      default:       n = 4'd10;
    endcase
    return n;
  endfunction

  logic [6:0]  w;
  logic        sgn;
  logic [63:0] acc;
  logic [3:0]  idx_raw;
  logic [3:0]  idx;
  logic [3:0]  byte_limit;
  logic [6:0]  shift;
  logic [7:0]  b;
  logic [6:0]  payload;
  logic [63:0] acc_or;
  logic [63:0] acc_new;
  logic [63:0] result;
  logic [63:0] hi_mask;
  logic [6:0]  rem;
  logic [7:0]  ns;
  logic        term;
  logic        done;
  lebwc_pkg::status_t status;

  always_comb begin
    // A value's first byte latches mode and width, clamped into range.
    if (!st_cur.busy) begin
      if (word_in.target_width == 7'd0) begin
        w = 7'd1;
      end else if (word_in.target_width > MaxW) begin
        w = MaxW;
      end else begin
        w = word_in.target_width;
      end
      sgn     = word_in.mode;
      acc     = '0;
      idx_raw = '0;
    end else begin
      w       = st_cur.width;
      sgn     = st_cur.sgn;
      acc     = st_cur.acc;
      idx_raw = st_cur.idx;
    end

    byte_limit = bytes_for(w);
    idx       = (idx_raw >= byte_limit) ? (byte_limit - 4'd1) : idx_raw;
    shift     = {idx, 3'b000} - {3'b000, idx};
    b         = word_in.data_byte;
    payload   = b[6:0] & lebwc_pkg::PAY_MASK[6:0];
    term      = (b & lebwc_pkg::CONT_BIT) == lebwc_pkg::BYTE_ZERO;
    acc_or    = acc | ({57'd0, payload} << shift);
    rem       = w - shift;
    ns        = {1'b0, shift} + 8'd7;
    hi_mask   = {64{1'b1}} << (w - 7'd1);

    acc_new = acc;
    result  = '0;
    status  = lebwc_pkg::ST_OK;
    done    = 1'b0;

    if (!sgn) begin
      if (ns > {1'b0, w} && (payload >> rem) != 7'd0) begin
        status = lebwc_pkg::ST_OVERFLOW;
        done   = 1'b1;
      end else begin
        acc_new = acc_or;
        if (term) begin
          result = acc_or;
          done   = 1'b1;
        end
      end
    end else if (shift == lebwc_pkg::LAST_SHIFT) begin
      // Tenth byte of a 64-bit signed value carries only bit 63.
      if (b != lebwc_pkg::BYTE_ZERO && b != lebwc_pkg::PAY_MASK) begin
        status = lebwc_pkg::ST_OVERFLOW;
      end else begin
        result = acc | {b[0], 63'd0};
      end
      done = 1'b1;
    end else begin
      acc_new = acc_or;
      if (term) begin
        if (ns < 8'd64 && (b & lebwc_pkg::SIGN_BIT) != lebwc_pkg::BYTE_ZERO) begin
          acc_new = acc_or | ({64{1'b1}} << ns);
        end
        // Bits from w-1 upward must all match the sign.
        if (w < 7'd64) begin
          if ((acc_new & hi_mask) != 64'd0 && (acc_new & hi_mask) != hi_mask) begin
            status = lebwc_pkg::ST_OVERFLOW;
          end
        end
        if (status == lebwc_pkg::ST_OK) begin
          result = acc_new;
        end
        done = 1'b1;
      end
    end

    if (!done) begin
      if (idx + 4'd1 >= byte_limit) begin
        status = lebwc_pkg::ST_TOO_LONG;
        done   = 1'b1;
      end else if (word_in.buffer_last) begin
        status = lebwc_pkg::ST_END;
        done   = 1'b1;
      end
    end

    st_nxt.width = w;
    st_nxt.sgn   = sgn;
    if (done) begin
      st_nxt.acc  = '0;
      st_nxt.idx  = '0;
      st_nxt.busy = 1'b0;
    end else begin
      st_nxt.acc  = acc_new;
      st_nxt.idx  = idx + 4'd1;
      st_nxt.busy = 1'b1;
    end

    res_valid           = done;
    res_word.value      = (status == lebwc_pkg::ST_OK) ? result : 64'd0;
    res_word.status     = status;
    res_word.byte_count = idx + 4'd1;
  end

endmodule : lebwc_step

`default_nettype wire

// ----- src/leb128_width_checked_decoder.sv -----
// A byte enters the input register when accepted; a value that it ends is
// registered in the output register when the byte advances, once the slot
// is free. Throughput: one byte per cycle, set by the state update of the
// decode step; a stalled output only holds bytes that end a value.
// Reset: synchronous active-low rst_n empties both registers and leaves the
// decoder idle, so the next byte starts a new value.
// ----------------------------------------------------------------------------
// leb128_width_checked_decoder: byte-serial LEB128 decoder with width checks
// Input register, decode step with held state, and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module leb128_width_checked_decoder #(
  parameter int MAX_WIDTH = lebwc_pkg::MAX_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  var lebwc_pkg::in_word_t     in_data,
  output logic                        out_valid,
  input  wire                         out_stall,
  output lebwc_pkg::out_word_t        out_data
);

  // Input register. It holds the word that the decode step works on.
  logic                  in_v_r;
  lebwc_pkg::in_word_t   in_d_r;

  // Decoder state between bytes of one value.
  lebwc_pkg::dec_state_t st_r;
  lebwc_pkg::dec_state_t st_nxt;

  // Output register.
  logic                  out_v_r;
  logic                  out_v_nxt;
  lebwc_pkg::out_word_t  out_d_r;

  logic                  res_valid;
  lebwc_pkg::out_word_t  res_word;
  logic                  out_free;
  logic                  advance;
  logic                  in_accept;

  lebwc_step #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_step (
    .st_cur    (st_r),
    .word_in   (in_d_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // The output slot is free when empty or when its word leaves this cycle.
  assign out_free = !out_v_r || !out_stall;

  // A byte that continues a value never needs the output slot, so it moves
  // on even while a finished value waits downstream.
  assign advance   = in_v_r && (!res_valid || out_free);
  assign in_stall  = in_v_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (advance && res_valid) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Control registers, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      out_v_r <= out_v_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_d_r <= in_data;
    end
    if (advance && res_valid) begin
      out_d_r <= res_word;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule : leb128_width_checked_decoder

`default_nettype wire

// ----- tb/sv/leb128_value_checker.sv -----
// ----------------------------------------------------------------------------
// leb128_value_checker: result checker for the width-checked LEB128 decoder
// Watches both channels, decodes every accepted byte on its own, and matches
// each finished value against the decoder's output word, field by field.
// ----------------------------------------------------------------------------
module leb128_value_checker #(
  parameter int MAX_WIDTH = lebwc_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  lebwc_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  lebwc_pkg::out_word_t out_data,
  output int                   mismatch_count,
  output int                   values_outstanding
);

  // Decoding state of the value in progress.
  logic [63:0] dec_acc;
  int unsigned dec_idx;
  int unsigned dec_width;
  bit          dec_signed;
  bit          dec_busy;

  lebwc_pkg::out_word_t expected_values[$];

  // Consumes one byte; returns 1 and fills res when the byte finishes a value.
  function automatic bit decode_byte(input lebwc_pkg::in_word_t w,
                                     output lebwc_pkg::out_word_t res);
    int unsigned tw, wid, byte_limit, shift, cnt, next_shift;
    logic [63:0] pay, acc, val, top, ones;
    lebwc_pkg::status_t st;
    bit          done;
    st   = lebwc_pkg::ST_OK;
    done = 1'b0;
    val  = '0;
    res  = '0;
    if (!dec_busy) begin
      tw = w.target_width;
      if (tw < 1) tw = 1;
      if (tw > MAX_WIDTH) tw = MAX_WIDTH;
      dec_width  = tw;
      dec_signed = w.mode;
      dec_acc    = '0;
      dec_idx    = 0;
      dec_busy   = 1'b1;
    end
    wid = dec_width;
    if (wid < 1 || wid > 64) wid = 1;
    byte_limit = (wid + 6) / 7;
    if (dec_idx >= byte_limit) dec_idx = byte_limit - 1;
    shift = 7 * dec_idx;
    cnt   = dec_idx + 1;
    pay   = {56'd0, w.data_byte & lebwc_pkg::PAY_MASK};
    acc   = dec_acc;

    if (!dec_signed) begin
      if (shift + 7 > wid && (pay >> (wid - shift)) != 0) begin
        st   = lebwc_pkg::ST_OVERFLOW;
        done = 1'b1;
      end else begin
        acc |= pay << shift;
        if ((w.data_byte & lebwc_pkg::CONT_BIT) == lebwc_pkg::BYTE_ZERO) begin
          val  = acc;
          done = 1'b1;
        end
      end
    end else if (shift == lebwc_pkg::LAST_SHIFT) begin
      // Tenth byte of a 64-bit signed value carries only the sign.
      if (w.data_byte != lebwc_pkg::BYTE_ZERO && w.data_byte != lebwc_pkg::PAY_MASK)
        st = lebwc_pkg::ST_OVERFLOW;
      else val = acc | ({63'd0, w.data_byte[0]} << 63);
      done = 1'b1;
    end else begin
      acc |= pay << shift;
      if ((w.data_byte & lebwc_pkg::CONT_BIT) == lebwc_pkg::BYTE_ZERO) begin
        next_shift = shift + 7;
        if (next_shift < 64 &&
            (w.data_byte & lebwc_pkg::SIGN_BIT) != lebwc_pkg::BYTE_ZERO)
          acc |= ~64'd0 << next_shift;
        if (wid < 64) begin
          top  = acc >> (wid - 1);
          ones = ~64'd0 >> (wid - 1);
          if (top != 0 && top != ones) st = lebwc_pkg::ST_OVERFLOW;
        end
        if (st == lebwc_pkg::ST_OK) val = acc;
        done = 1'b1;
      end
    end

    if (!done) begin
      if (dec_idx + 1 >= byte_limit) begin
        st   = lebwc_pkg::ST_TOO_LONG;
        done = 1'b1;
      end else if (w.buffer_last) begin
        st   = lebwc_pkg::ST_END;
        done = 1'b1;
      end
    end

    if (!done) begin
      dec_acc = acc;
      dec_idx = dec_idx + 1;
      return 1'b0;
    end

    res.value      = (st == lebwc_pkg::ST_OK) ? val : '0;
    res.status     = st;
    res.byte_count = cnt[3:0];
    dec_acc  = '0;
    dec_idx  = 0;
    dec_busy = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    lebwc_pkg::out_word_t want;
    lebwc_pkg::out_word_t pred;
    bit                   made;
    if (!rst_n) begin
      dec_acc    = '0;
      dec_idx    = 0;
      dec_width  = 0;
      dec_signed = 1'b0;
      dec_busy   = 1'b0;
      expected_values.delete();
      mismatch_count     = 0;
      values_outstanding = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          $error("out_data: unexpected word, value %h status %0d byte_count %0d",
                 out_data.value, out_data.status, out_data.byte_count);
          mismatch_count++;
        end else begin
          want = expected_values.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_data.value);
            mismatch_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count,
                   out_data.byte_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        made = decode_byte(in_data, pred);
        if (made) expected_values.insert(expected_values.size(), pred);
      end
      values_outstanding = expected_values.size();
    end
  end

endmodule : leb128_value_checker

// ----- tb/sv/tb_leb128_width_checked_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_leb128_width_checked_decoder: testbench top for the LEB128 decoder
// Drives encoded byte streams with random pacing and output stalls; a checker
// beside the decoder predicts every value and reports mismatches.
// ----------------------------------------------------------------------------
module tb_leb128_width_checked_decoder;

  localparam int MAX_WIDTH = lebwc_pkg::MAX_WIDTH_DEF;

  // Number of bytes sent in the random part, after the directed words.
  localparam int RANDOM_BYTES = 1750;

  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;

  // Quiet cycles after the last expected value, covering the input and output registers.
  localparam int DRAIN_CYCLES = 8;

  localparam int unsigned RUN_LIMIT = 200000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  lebwc_pkg::in_word_t  in_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lebwc_pkg::out_word_t out_data;

  int          mismatch_count;
  int          values_outstanding;
  int          hold_ask    = 0;
  int          bytes_sent  = 0;
  int          burst_left  = 0;
  int unsigned cycle_count = 0;

  leb128_width_checked_decoder #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  leb128_value_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data           (out_data),
    .mismatch_count     (mismatch_count),
    .values_outstanding (values_outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("leb128_width_checked_decoder test failed");
      $finish;
    end
  end

  // Offers one word and waits until the decoder takes it. The sender works in
  // bursts: when a burst runs out, valid drops for a random gap. Long bursts
  // give stretches of back-to-back bytes. Since pacing is per byte, gaps land
  // in the middle of values as well as between them.
  task automatic send_raw(input logic [7:0] data, input logic sgn,
                          input logic [6:0] tw, input logic last);
    lebwc_pkg::in_word_t w;
    int                  gap;
    w.data_byte    = data;
    w.mode         = sgn;
    w.target_width = tw;
    w.buffer_last  = last;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends raw as an LEB128 encoding of exactly nbytes bytes. The source is
  // zero- or sign-extended so that padding bytes come out naturally, which
  // makes longer-than-minimal encodings decode to the same value. Only the
  // first byte's mode and width matter, so the later ones carry random junk
  // to prove they are ignored. A buffer end now and then in the middle gives
  // the unexpected-end case; corrupt scrambles the final byte.
  task automatic send_leb(input logic sgn, input logic [6:0] tw, input logic [63:0] raw,
                          input int nbytes, input logic end_flag, input logic corrupt);
    logic [76:0] enc;
    logic [7:0]  b;
    logic [7:0]  flip;
    enc = sgn ? {{13{raw[63]}}, raw} : {13'd0, raw};
    for (int i = 0; i < nbytes; i++) begin
      b = {(i < nbytes - 1) ? 1'b1 : 1'b0, enc[7 * i +: 7]};
      if (corrupt && i == nbytes - 1) begin
        flip = 8'($urandom_range(1, 255));
        b    = b ^ flip;
      end
      send_raw(b,
               (i == 0) ? sgn : 1'($urandom_range(0, 1)),
               (i == 0) ? tw  : 7'($urandom_range(0, 127)),
               (i == nbytes - 1) ? end_flag : 1'($urandom_range(0, 39) == 0));
    end
  endtask

  // One random value. Widths lean toward the edges: full 64 bits, the
  // byte-boundary widths, and out-of-range codes that the decoder clamps.
  // Most values fit their width, so that the decoder really produces
  // results; a tenth do not, to exercise the overflow checks. Lengths run from
  // truncated to one byte over the limit.
  task automatic send_random_value();
    logic        sgn;
    logic [6:0]  tw;
    logic [63:0] raw;
    int          ew, byte_limit, nbytes, r, v;
    sgn = 1'($urandom_range(0, 1));
    r   = $urandom_range(0, 99);
    if (r < 55) begin
      tw = 7'($urandom_range(1, 64));
    end else if (r < 70) begin
      tw = 7'd64;
    end else if (r < 85) begin
      case ($urandom_range(0, 5))
        0: tw = 7'd1;
        1: tw = 7'd7;
        2: tw = 7'd8;
        3: tw = 7'd14;
        4: tw = 7'd15;
        default: tw = 7'd63;
      endcase
    end else begin
      tw = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
    end
    ew = (tw == 0) ? 1 : ((tw > MAX_WIDTH) ? MAX_WIDTH : int'(tw));
    byte_limit = (ew + 6) / 7;

    if ($urandom_range(0, 4) == 0) begin
      v   = int'($urandom_range(0, 255)) - 128;
      raw = {{32{v[31]}}, v};
    end else begin
      raw = {$urandom, $urandom};
    end
    if ($urandom_range(0, 9) != 0) begin
      if (sgn) raw = $signed(raw << (64 - ew)) >>> (64 - ew);
      else raw = raw & (~64'd0 >> (64 - ew));
    end

    r = $urandom_range(0, 99);
    if (r < 45) nbytes = byte_limit;
    else if (r < 93) nbytes = $urandom_range(1, byte_limit);
    else nbytes = byte_limit + 1;

    send_leb(sgn, tw, raw, nbytes, 1'($urandom_range(0, 1)),
             $urandom_range(0, 9) == 0);
  endtask

  // A short run of bytes with every field random, width codes included.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      send_raw(8'($urandom), 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 3) == 0));
    end
  endtask

  // Receiver: stalls on a pattern of its own that changes in phases of random
  // length (never, rarely, mostly, alternating). When the stimulus asks
  // for it, it holds off for a long stretch so that the output register and
  // then the input register fill up and the decoder stalls its input.
  initial begin
    int phase_kind;
    int phase_left;
    int holds_served;
    phase_kind   = 0;
    phase_left   = 0;
    holds_served = 0;
    forever begin
      if (hold_ask != holds_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served = hold_ask;
      end else begin
        if (phase_left == 0) begin
          phase_kind = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (phase_kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int goal;
    bit hold_asked;
    bit pause_done;
    hold_asked = 1'b0;
    pause_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words. Unsigned zero in one byte, with the buffer end flag also set.
    send_raw(8'h00, 1'b0, 7'd64, 1'b1);
    // 255 needs two bytes at width 8.
    send_raw(8'hff, 1'b0, 7'd8, 1'b0);
    send_raw(8'h01, 1'b0, 7'd8, 1'b0);
    // A payload bit at position 8 overflows an 8-bit unsigned value.
    send_raw(8'h80, 1'b0, 7'd8, 1'b0);
    send_raw(8'h02, 1'b0, 7'd8, 1'b0);
    // One-bit unsigned value with bit 1 set.
    send_raw(8'h02, 1'b0, 7'd1, 1'b0);
    // Continuation on the only byte a 7-bit value may have: too long.
    send_raw(8'h80, 1'b0, 7'd7, 1'b0);
    // Continuation on the final byte of the buffer: unexpected end.
    send_raw(8'h80, 1'b0, 7'd64, 1'b1);
    // Signed minus one at width 8.
    send_raw(8'h7f, 1'b1, 7'd8, 1'b0);
    // Signed -256 does not fit in 8 bits.
    send_raw(8'h80, 1'b1, 7'd8, 1'b0);
    send_raw(8'h7e, 1'b1, 7'd8, 1'b0);
    // Width code zero acts as one bit; signed +1 then does not fit.
    send_raw(8'h01, 1'b1, 7'd0, 1'b0);
    // Width code 127 is clamped to the widest value.
    send_raw(8'h85, 1'b0, 7'd127, 1'b0);
    send_raw(8'h7f, 1'b1, 7'd3, 1'b1);
    // 64-bit signed minus one: nine continuation bytes, then 0x7f in the
    // tenth, whose low bit lands in bit 63.
    send_leb(1'b1, 7'd64, ~64'd0, 10, 1'b1, 1'b0);

    // Random part. Partway through, the receiver holds off while the sender
    // keeps offering; later the sender stops until every value has come out.
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      if (!hold_asked && bytes_sent >= goal - 1250) begin
        hold_ask  <= hold_ask + 1;
        hold_asked = 1'b1;
      end
      if (!pause_done && bytes_sent >= goal - 600) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (values_outstanding != 0) @(negedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_random_value();
    end

    // Drain: wait for the last expected value, then give a stray word time
    // to show up before the verdict.
    in_valid <= 1'b0;
    @(negedge clk);
    while (values_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && values_outstanding == 0) begin
      $display("leb128_width_checked_decoder test passed");
    end else begin
      $display("leb128_width_checked_decoder test failed");
    end
    $finish;
  end

endmodule : tb_leb128_width_checked_decoder

// ----- filelist.f -----
src/lebwc_pkg.sv
src/lebwc_step.sv
src/leb128_width_checked_decoder.sv
tb/sv/leb128_value_checker.sv
tb/sv/tb_leb128_width_checked_decoder.sv
